/* rtl/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SFVA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfva: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SFVA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfva: next-cycle check failed");

`endif

/* rtl/sfva_pkg.sv */
// Shared types and constants for the sound effect voice allocator.
package sfva_pkg;

    localparam int SOUND_ID_W   = 16;
    localparam int SLOT_PORT_W  = 3;
    localparam int VOL_W        = 8;
    localparam int MASK_W       = 8;

    localparam logic [VOL_W-1:0] FULL_VOLUME = 8'd255;

    typedef enum logic [2:0] {
        KIND_PLAY       = 3'd0,
        KIND_SET_VOLUME = 3'd1,
        KIND_STOP_SLOT  = 3'd2,
        KIND_STOP_SOUND = 3'd3,
        KIND_STOP_ALL   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        MODE_DIRECT     = 2'd0,
        MODE_ANY        = 2'd1,
        MODE_NO_OVERLAP = 2'd2
    } play_mode_t;

endpackage

/* rtl/sfva_slot_search.sv */
// Priority search over the slot table: lowest slot with a sound id, lowest free slot.
module sfva_slot_search #(
    parameter int SLOT_COUNT = 8,
    parameter int ID_WIDTH   = 16
) (
    input  logic [ID_WIDTH-1:0]                                  slot_sound [SLOT_COUNT],
    input  logic [SLOT_COUNT-1:0]                                playing,
    input  logic [SLOT_COUNT-1:0]                                reserved,
    input  logic [ID_WIDTH-1:0]                                  id,
    output logic                                                 sound_hit,
    output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] sound_idx,
    output logic                                                 free_hit,
    output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] free_idx
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Scan from the top down so the lowest match wins.
    always_comb
    begin
        sound_hit = 1'b0;
        sound_idx = '0;
        free_hit  = 1'b0;
        free_idx  = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if ((id != '0) && (slot_sound[i] == id))
            begin
                sound_hit = 1'b1;
                sound_idx = SLOT_W'(i);
            end
            if (!reserved[i] && !playing[i])
            begin
                free_hit = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

endmodule

/* rtl/sound_effect_voice_allocator.sv */
// Top level of the sound effect voice allocator: slot table, request and response stages.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+----------------------------------------------
//  request   | req_valid / req_stall   | kind, play_mode, slot_index, sound_id,
//            |                         | volume_left, volume_right
//  response  | rsp_valid / rsp_stall   | granted, chosen_slot, playing_mask
//  config    | cfg_write_en            | cfg_write_data (reserved slot mask)
//
//  One request per cycle when nothing stalls; search and table update sit between the
//  request and response registers, so each request sees the table left by the one before.
//  An accepted request passes through the request register and then the response
//  register; a held response can delay it.
//  req_stall rises only while a request is parked behind a held response.
//  rst_n clears the slot table, the reserved mask and both valid flags.
module sound_effect_voice_allocator
    import sfva_pkg::*;
#(
    parameter int SLOT_COUNT = 8,
    parameter int ID_WIDTH   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write_en,
    input  logic [MASK_W-1:0]      cfg_write_data,

    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [2:0]             kind,
    input  logic [1:0]             play_mode,
    input  logic [SLOT_PORT_W-1:0] slot_index,
    input  logic [SOUND_ID_W-1:0]  sound_id,
    input  logic [VOL_W-1:0]       volume_left,
    input  logic [VOL_W-1:0]       volume_right,

    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic                   granted,
    output logic [SLOT_PORT_W-1:0] chosen_slot,
    output logic [MASK_W-1:0]      playing_mask
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // ------------------------------------------------------------------
    // Configuration: reserved mask; write it only while idle (the block does not enforce this).
    // ------------------------------------------------------------------
    logic [MASK_W-1:0] reserved_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            reserved_reg <= cfg_write_data;
        end
    end

    // Only the first eight slots can be reserved; pad with zeros beyond that.
    logic [SLOT_COUNT+MASK_W-1:0] reserved_wide;
    logic [SLOT_COUNT-1:0]        reserved_vec;

    assign reserved_wide = {{SLOT_COUNT{1'b0}}, reserved_reg};
    assign reserved_vec  = reserved_wide[SLOT_COUNT-1:0];

    // ------------------------------------------------------------------
    // Handshake control.
    // ------------------------------------------------------------------
    logic req_valid_reg;
    logic rsp_valid_reg;
    logic advance;
    logic fire;
    logic req_take;

    // Response register can load when empty or being drained this cycle.
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = req_valid_reg && advance;
    assign req_stall = req_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    // ------------------------------------------------------------------
    // Request register.
    // ------------------------------------------------------------------
    logic [2:0]             kind_reg;
    logic [1:0]             play_mode_reg;
    logic [SLOT_PORT_W-1:0] slot_index_reg;
    logic [SOUND_ID_W-1:0]  sound_id_reg;
    logic [VOL_W-1:0]       volume_left_reg;
    logic [VOL_W-1:0]       volume_right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_take)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            kind_reg         <= kind;
            play_mode_reg    <= play_mode;
            slot_index_reg   <= slot_index;
            sound_id_reg     <= sound_id;
            volume_left_reg  <= volume_left;
            volume_right_reg <= volume_right;
        end
    end

    // ------------------------------------------------------------------
    // Slot table.
    // ------------------------------------------------------------------
    logic [ID_WIDTH-1:0]   sound_reg  [SLOT_COUNT];
    logic [ID_WIDTH-1:0]   sound_next [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] playing_reg;
    logic [SLOT_COUNT-1:0] playing_next;
    logic [VOL_W-1:0]      vol_left_reg   [SLOT_COUNT];
    logic [VOL_W-1:0]      vol_left_next  [SLOT_COUNT];
    logic [VOL_W-1:0]      vol_right_reg  [SLOT_COUNT];
    logic [VOL_W-1:0]      vol_right_next [SLOT_COUNT];

    // Sound id trimmed or zero-extended to the stored width.
    logic [ID_WIDTH+SOUND_ID_W-1:0] id_wide;
    logic [ID_WIDTH-1:0]            id;

    assign id_wide = {{ID_WIDTH{1'b0}}, sound_id_reg};
    assign id      = id_wide[ID_WIDTH-1:0];

    // Addressed slot: valid only when inside the table.
    logic [5:0]        idx_ext;
    logic              idx_ok;
    logic [SLOT_W-1:0] idx_sel;

    assign idx_ext = 6'(slot_index_reg);
    assign idx_ok  = idx_ext < 6'(SLOT_COUNT);
    assign idx_sel = SLOT_W'(slot_index_reg);

    logic              sound_hit;
    logic [SLOT_W-1:0] sound_idx;
    logic              free_hit;
    logic [SLOT_W-1:0] free_idx;

    sfva_slot_search #(
        .SLOT_COUNT (SLOT_COUNT),
        .ID_WIDTH   (ID_WIDTH)
    ) u_search (
        .slot_sound (sound_reg),
        .playing    (playing_reg),
        .reserved   (reserved_vec),
        .id         (id),
        .sound_hit  (sound_hit),
        .sound_idx  (sound_idx),
        .free_hit   (free_hit),
        .free_idx   (free_idx)
    );

    // ------------------------------------------------------------------
    // Request decode and table update.
    // ------------------------------------------------------------------
    logic              granted_next;
    logic [SLOT_W-1:0] chosen_next;
    logic              take;
    logic [SLOT_W-1:0] take_idx;

    always_comb
    begin
        sound_next     = sound_reg;
        playing_next   = playing_reg;
        vol_left_next  = vol_left_reg;
        vol_right_next = vol_right_reg;
        granted_next   = 1'b0;
        chosen_next    = '0;
        take           = 1'b0;
        take_idx       = '0;

        case (kind_t'(kind_reg))
            KIND_PLAY:
            begin
                // A zero id is never played.
                if (id != '0)
                begin
                    case (play_mode_t'(play_mode_reg))
                        MODE_DIRECT:
                        begin
                            // Refuse an out-of-range slot and a reserved slot busy with another sound.
                            if (idx_ok && !(reserved_vec[idx_sel] && playing_reg[idx_sel]
                                            && (sound_reg[idx_sel] != id)))
                            begin
                                take     = 1'b1;
                                take_idx = idx_sel;
                            end
                        end
                        MODE_ANY:
                        begin
                            take     = free_hit;
                            take_idx = free_idx;
                        end
                        MODE_NO_OVERLAP:
                        begin
                            // Reuse the slot already holding this sound, else any free one.
                            if (sound_hit)
                            begin
                                take     = 1'b1;
                                take_idx = sound_idx;
                            end
                            else
                            begin
                                take     = free_hit;
                                take_idx = free_idx;
                            end
                        end
                        default:
                        begin
                            take = 1'b0;
                        end
                    endcase
                end
                if (take)
                begin
                    sound_next[take_idx]     = id;
                    playing_next[take_idx]   = 1'b1;
                    vol_left_next[take_idx]  = FULL_VOLUME;
                    vol_right_next[take_idx] = FULL_VOLUME;
                    granted_next             = 1'b1;
                    chosen_next              = take_idx;
                end
            end
            KIND_SET_VOLUME:
            begin
                if (idx_ok)
                begin
                    vol_left_next[idx_sel]  = volume_left_reg;
                    vol_right_next[idx_sel] = volume_right_reg;
                    granted_next            = 1'b1;
                    chosen_next             = idx_sel;
                end
            end
            KIND_STOP_SLOT:
            begin
                if (idx_ok)
                begin
                    playing_next[idx_sel] = 1'b0;
                    granted_next          = 1'b1;
                    chosen_next           = idx_sel;
                end
            end
            KIND_STOP_SOUND:
            begin
                // Keep the id stored so a later no-overlap play finds the slot.
                if (sound_hit)
                begin
                    playing_next[sound_idx] = 1'b0;
                    granted_next            = 1'b1;
                    chosen_next             = sound_idx;
                end
            end
            KIND_STOP_ALL:
            begin
                playing_next = '0;
                granted_next = 1'b1;
            end
            default:
            begin
                granted_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                sound_reg[i]     <= '0;
                vol_left_reg[i]  <= '0;
                vol_right_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            playing_reg   <= playing_next;
            sound_reg     <= sound_next;
            vol_left_reg  <= vol_left_next;
            vol_right_reg <= vol_right_next;
        end
    end

    // ------------------------------------------------------------------
    // Response register.
    // ------------------------------------------------------------------
    logic [SLOT_W+SLOT_PORT_W-1:0] chosen_wide;
    logic [SLOT_COUNT+MASK_W-1:0]  playing_wide;
    logic                          granted_reg;
    logic [SLOT_PORT_W-1:0]        chosen_reg;
    logic [MASK_W-1:0]             playing_mask_reg;

    // Report the low three bits of the slot and the first eight playing flags.
    assign chosen_wide  = {{SLOT_PORT_W{1'b0}}, chosen_next};
    assign playing_wide = {{MASK_W{1'b0}}, playing_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            granted_reg      <= granted_next;
            chosen_reg       <= chosen_wide[SLOT_PORT_W-1:0];
            playing_mask_reg <= playing_wide[MASK_W-1:0];
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign granted      = granted_reg;
    assign chosen_slot  = chosen_reg;
    assign playing_mask = playing_mask_reg;

endmodule

/* rtl/sfva_checker.sv */
// Port-level checker for the voice allocator, bound to the top level.
`include "assert_macros.svh"

module sfva_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_stall,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input logic       granted,
    input logic [2:0] chosen_slot,
    input logic [7:0] playing_mask
);

    // Held response keeps its payload.
    `SFVA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
        rsp_valid && $stable(granted) && $stable(chosen_slot) && $stable(playing_mask))

    // Refusals never name a slot.
    `SFVA_ASSERT_NOW(a_refused_slot_zero, rsp_valid && !granted, chosen_slot == 3'd0)

    // Requests back up only behind a held response.
    `SFVA_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall)

    // An accepted request is answered through the request and response registers unless the response is held.
    `SFVA_ASSERT_NEXT(a_rsp_follows,
        (req_valid && !req_stall) ##1 !(rsp_valid && rsp_stall), rsp_valid)

endmodule

bind sound_effect_voice_allocator sfva_checker u_sfva_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .granted      (granted),
    .chosen_slot  (chosen_slot),
    .playing_mask (playing_mask)
);
